// ===== rtl/tvi_pkg.sv =====
// ----------------------------------------------------------------------------
// tvi_pkg: shared types and constants
// Codes, configuration record and controller/datapath command and status.
// ----------------------------------------------------------------------------
package tvi_pkg;

  localparam logic [1:0] REQ_TICK    = 2'd0;
  localparam logic [1:0] REQ_MOVE    = 2'd1;
  localparam logic [1:0] REQ_RELEASE = 2'd2;
  localparam logic [1:0] REQ_UNUSED  = 2'd3;

  localparam logic [1:0] KIND_DRAG  = 2'd0;
  localparam logic [1:0] KIND_COAST = 2'd1;
  localparam logic [1:0] KIND_STOP  = 2'd2;

  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_DRAG  = 2'd1;
  localparam logic [1:0] MODE_COAST = 2'd2;

  localparam logic [1:0] CFG_ENABLE    = 2'd0;
  localparam logic [1:0] CFG_DECAY     = 2'd1;
  localparam logic [1:0] CFG_THRESHOLD = 2'd2;
  localparam logic [1:0] CFG_KEEP      = 2'd3;

  localparam logic        RST_ENABLE    = 1'b1;
  localparam logic [15:0] RST_DECAY     = 16'd64225;
  localparam logic [15:0] RST_THRESHOLD = 16'd655;
  localparam logic [4:0]  RST_KEEP      = 5'd6;

  localparam int unsigned DIV_W     = 48;
  localparam int unsigned DVS_W     = 24;
  localparam int unsigned ELAPSED_W = 24;

  typedef enum logic [1:0] {
    MUL_PROBE,
    MUL_DECAY,
    MUL_STEP_DT,
    MUL_ELAPSED
  } mul_sel_e;

  typedef struct packed {
    logic        enable;
    logic [15:0] decay_factor;
    logic [15:0] stop_threshold;
    logic [4:0]  keep_count;
  } cfg_t;

  typedef struct packed {
    logic     load;
    logic     clear;
    logic     tick_add;
    logic     div_sample;
    logic     ring_write;
    logic     sum_start;
    logic     sel_init;
    logic     sel_start;
    logic     take;
    logic     div_keep;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     speed_from_div;
    logic     speed_from_mul;
    logic     step_drag;
    logic     step_coast;
    logic     set_stop;
    logic     emit;
    logic     acc_sum;
    logic     acc_sel;
  } cmd_t;

  typedef struct packed {
    logic [1:0] req;
    logic       elapsed_zero;
    logic       div_done;
    logic       scan_done;
    logic       last_pick;
    logic       probe_over;
    logic       out_free;
  } sts_t;

endpackage

// ===== rtl/tvi_if.sv =====
// ----------------------------------------------------------------------------
// tvi channel interfaces
// Valid/ready channels for input items, result items and register writes.
// ----------------------------------------------------------------------------
interface tvi_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        req_type;
  logic [15:0]       dt;
  logic signed [31:0] delta;
  modport source (output valid, req_type, dt, delta, input ready);
  modport sink (input valid, req_type, dt, delta, output ready);
endinterface

interface tvi_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         event_kind;
  logic signed [31:0] step_amount;
  logic signed [31:0] speed;
  modport source (output valid, event_kind, step_amount, speed, input ready);
  modport sink (input valid, event_kind, step_amount, speed, output ready);
endinterface

interface tvi_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/tvi_div.sv =====
// ----------------------------------------------------------------------------
// tvi_div: restoring divider
// Unsigned 48 by 24 bit division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tvi_div
  import tvi_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DIV_W-1:0]   dividend_i,
  input  logic [DVS_W-1:0]   divisor_i,
  output logic               done_o,
  output logic [DIV_W-1:0]   quot_o
);

  logic [DIV_W-1:0] quot_q, quot_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVS_W-1:0] dvs_q;
  logic [5:0]       cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;

  assign trial = {rem_q, quot_q[DIV_W-1]};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = done_q;
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      cnt_d  = 6'(DIV_W - 1);
      busy_d = 1'b1;
      done_d = 1'b0;
    end else if (busy_q) begin
      if (!diff[DVS_W]) begin
        rem_d  = diff[DVS_W-1:0];
        quot_d = {quot_q[DIV_W-2:0], 1'b1};
      end else begin
        rem_d  = trial[DVS_W-1:0];
        quot_d = {quot_q[DIV_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    if (start_i) dvs_q <= divisor_i;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ===== rtl/tvi_dp.sv =====
// ----------------------------------------------------------------------------
// tvi_dp: velocity datapath
// Sample ring, scan logic for the trimmed mean, shared multiplier, divider
// and the result register.
// ----------------------------------------------------------------------------
module tvi_dp
  import tvi_pkg::*;
#(
  parameter int unsigned RING_DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  input  cfg_t               cfg_i,
  input  logic [1:0]         req_type_i,
  input  logic [15:0]        dt_i,
  input  logic signed [31:0] delta_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         event_kind_o,
  output logic signed [31:0] step_amount_o,
  output logic signed [31:0] speed_o
);

  localparam int unsigned AW = $clog2(RING_DEPTH);
  localparam int unsigned CW = $clog2(RING_DEPTH + 1);
  localparam int unsigned TW = 32 + AW;
  localparam int unsigned DW = 34 + AW;
  localparam logic signed [DW-1:0] DEPTH_S = DW'(RING_DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(RING_DEPTH - 1);

  // latched item
  logic [1:0]         req_q;
  logic [15:0]        dt_q;
  logic signed [31:0] delta_q;

  logic [ELAPSED_W-1:0] elapsed_q;
  logic signed [31:0]   speed_q;
  logic [AW-1:0]        slot_q;
  logic [AW-1:0]        slot_nx;
  logic [RING_DEPTH-1:0] vld_q;

  // ring memory
  logic signed [31:0] ring_mem [RING_DEPTH];
  logic signed [31:0] rd_q;

  // scan
  logic          scan_act_q;
  logic [AW-1:0] scan_idx_q;
  logic          rv_q;
  logic [AW-1:0] ridx_q;
  logic signed [31:0] val;

  logic signed [TW-1:0] total_q;
  logic signed [TW-1:0] acc_q;
  logic signed [DW-1:0] dist_raw;
  logic [DW-1:0]        dev;
  logic [DW-1:0]        best_dist_q;
  logic [AW-1:0]        best_idx_q;
  logic signed [31:0]   best_val_q;
  logic                 best_found_q;
  logic [RING_DEPTH-1:0] taken_q;
  logic [CW-1:0]        pick_q;
  logic [CW-1:0]        keep_eff;

  // divider
  logic               div_start;
  logic [DIV_W-1:0]   div_dvd;
  logic [DVS_W-1:0]   div_dvs;
  logic               div_done;
  logic [DIV_W-1:0]   div_quot;
  logic               div_neg_q;
  logic signed [31:0] div_res;
  logic [31:0]        dmag;
  logic [TW-1:0]      acc_mag;

  // multiplier
  logic [23:0]        mul_b;
  logic signed [56:0] prod;
  logic signed [56:0] prod_q;
  logic signed [56:0] prod_adj;
  logic signed [40:0] q16;
  logic [40:0]        q16_mag;
  logic signed [31:0] q16_sat;

  logic [ELAPSED_W:0] elapsed_sum;

  logic [1:0]         res_kind_q;
  logic signed [31:0] res_step_q;
  logic               out_valid_q;
  logic [1:0]         out_kind_q;
  logic signed [31:0] out_step_q;
  logic signed [31:0] out_speed_q;

  always_comb begin
    if (cfg_i.keep_count == 5'd0) keep_eff = CW'(1);
    else if (32'(cfg_i.keep_count) > RING_DEPTH) keep_eff = CW'(RING_DEPTH);
    else keep_eff = CW'(cfg_i.keep_count);
  end

  assign slot_nx = (slot_q == LAST_IDX) ? '0 : slot_q + AW'(1);

  // divider operands
  assign dmag      = delta_q[31] ? (~delta_q + 32'sd1) : delta_q;
  assign acc_mag   = acc_q[TW-1] ? TW'(-acc_q) : TW'(acc_q);
  assign div_start = cmd_i.div_sample | cmd_i.div_keep;
  assign div_dvd   = cmd_i.div_sample ? {dmag, 16'd0} : DIV_W'(acc_mag);
  assign div_dvs   = cmd_i.div_sample ? elapsed_q : DVS_W'(keep_eff);

  tvi_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // sign and saturate the quotient
  always_comb begin
    if (!div_neg_q) begin
      if (div_quot > DIV_W'(32'h7FFF_FFFF)) div_res = 32'sh7FFF_FFFF;
      else div_res = div_quot[31:0];
    end else begin
      if (div_quot > DIV_W'(32'h8000_0000)) div_res = 32'sh8000_0000;
      else div_res = -div_quot[31:0];
    end
  end

  // shared multiplier, q16 with truncation toward zero
  always_comb begin
    case (cmd_i.mul_sel)
      MUL_DECAY:   mul_b = 24'(cfg_i.decay_factor);
      MUL_ELAPSED: mul_b = elapsed_q;
      default:     mul_b = 24'(dt_q);
    endcase
  end
  assign prod     = 57'(speed_q) * 57'(signed'({1'b0, mul_b}));
  assign prod_adj = prod_q + (prod_q[56] ? 57'sd65535 : 57'sd0);
  assign q16      = prod_adj[56:16];
  assign q16_mag  = q16[40] ? 41'(-q16) : 41'(q16);

  always_comb begin
    if (q16 > 41'sh0_7FFF_FFFF) q16_sat = 32'sh7FFF_FFFF;
    else if (q16 < -41'sh0_8000_0000) q16_sat = 32'sh8000_0000;
    else q16_sat = q16[31:0];
  end

  // scan data stage
  assign val      = vld_q[ridx_q] ? rd_q : 32'sd0;
  assign dist_raw = DW'(val) * DEPTH_S - DW'(total_q);
  assign dev      = dist_raw[DW-1] ? DW'(-dist_raw) : DW'(dist_raw);

  assign elapsed_sum = {1'b0, elapsed_q} + (ELAPSED_W+1)'(dt_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.ring_write) ring_mem[slot_nx] <= div_res;
    rd_q <= ring_mem[scan_idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elapsed_q    <= '0;
      speed_q      <= '0;
      slot_q       <= '0;
      vld_q        <= '0;
      scan_act_q   <= 1'b0;
      scan_idx_q   <= '0;
      rv_q         <= 1'b0;
      ridx_q       <= '0;
      taken_q      <= '0;
      pick_q       <= '0;
      best_found_q <= 1'b0;
      div_neg_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        vld_q     <= '0;
        slot_q    <= '0;
        elapsed_q <= '0;
      end
      if (cmd_i.tick_add) begin
        elapsed_q <= elapsed_sum[ELAPSED_W] ? '1 : elapsed_sum[ELAPSED_W-1:0];
      end
      if (cmd_i.ring_write) begin
        slot_q         <= slot_nx;
        vld_q[slot_nx] <= 1'b1;
      end
      if (cmd_i.div_sample) div_neg_q <= delta_q[31];
      if (cmd_i.div_keep) div_neg_q <= acc_q[TW-1];
      if (cmd_i.speed_from_div) speed_q <= div_res;
      if (cmd_i.speed_from_mul) speed_q <= q16[31:0];
      if (cmd_i.step_drag) elapsed_q <= '0;

      // address stage
      if (cmd_i.sum_start || cmd_i.sel_start) begin
        scan_act_q <= 1'b1;
        scan_idx_q <= '0;
      end else if (scan_act_q) begin
        scan_idx_q <= scan_idx_q + AW'(1);
        if (scan_idx_q == LAST_IDX) scan_act_q <= 1'b0;
      end
      rv_q   <= scan_act_q;
      ridx_q <= scan_idx_q;

      if (cmd_i.sel_init) begin
        taken_q <= '0;
        pick_q  <= '0;
      end
      if (cmd_i.sel_start) best_found_q <= 1'b0;
      else if (cmd_i.acc_sel && rv_q && !taken_q[ridx_q] &&
               (!best_found_q || dev < best_dist_q)) begin
        best_found_q <= 1'b1;
      end
      if (cmd_i.take) begin
        taken_q[best_idx_q] <= 1'b1;
        pick_q              <= pick_q + CW'(1);
      end

      if (cmd_i.emit) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q   <= req_type_i;
      dt_q    <= dt_i;
      delta_q <= delta_i;
    end
    if (cmd_i.mul_en) prod_q <= prod;
    if (cmd_i.sum_start) total_q <= '0;
    else if (cmd_i.acc_sum && rv_q) total_q <= total_q + TW'(val);
    if (cmd_i.sel_init) acc_q <= '0;
    else if (cmd_i.take) acc_q <= acc_q + TW'(best_val_q);
    if (cmd_i.acc_sel && rv_q && !taken_q[ridx_q] &&
        (!best_found_q || dev < best_dist_q)) begin
      best_dist_q <= dev;
      best_idx_q  <= ridx_q;
      best_val_q  <= val;
    end
    if (cmd_i.step_drag) begin
      res_kind_q <= KIND_DRAG;
      res_step_q <= q16_sat;
    end
    if (cmd_i.step_coast) begin
      res_kind_q <= KIND_COAST;
      res_step_q <= q16_sat;
    end
    if (cmd_i.set_stop) begin
      res_kind_q <= KIND_STOP;
      res_step_q <= '0;
    end
    if (cmd_i.emit) begin
      out_kind_q  <= res_kind_q;
      out_step_q  <= res_step_q;
      out_speed_q <= speed_q;
    end
  end

  assign sts_o.req          = req_q;
  assign sts_o.elapsed_zero = (elapsed_q == '0);
  assign sts_o.div_done     = div_done;
  assign sts_o.scan_done    = rv_q && (ridx_q == LAST_IDX);
  assign sts_o.last_pick    = (pick_q + CW'(1)) == keep_eff;
  assign sts_o.probe_over   = q16_mag > 41'(cfg_i.stop_threshold);
  assign sts_o.out_free     = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign event_kind_o  = out_kind_q;
  assign step_amount_o = out_step_q;
  assign speed_o       = out_speed_q;

endmodule

// ===== rtl/tvi_ctrl.sv =====
// ----------------------------------------------------------------------------
// tvi_ctrl: sequencer
// Decodes each item and steps the datapath through divide, scan and multiply.
// ----------------------------------------------------------------------------
module tvi_ctrl
  import tvi_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic enable_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DEC   = 4'd1;
  localparam logic [3:0] S_DIVS  = 4'd2;
  localparam logic [3:0] S_SUM   = 4'd3;
  localparam logic [3:0] S_SEL   = 4'd4;
  localparam logic [3:0] S_TAKE  = 4'd5;
  localparam logic [3:0] S_KST   = 4'd6;
  localparam logic [3:0] S_DIVK  = 4'd7;
  localparam logic [3:0] S_MULD  = 4'd8;
  localparam logic [3:0] S_STEPD = 4'd9;
  localparam logic [3:0] S_PROBE = 4'd10;
  localparam logic [3:0] S_DECAY = 4'd11;
  localparam logic [3:0] S_SPD   = 4'd12;
  localparam logic [3:0] S_STEPC = 4'd13;
  localparam logic [3:0] S_EMIT  = 4'd14;

  logic [3:0] state_q, state_d;
  logic [1:0] mode_q, mode_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    cmd_o   = '0;
    cmd_o.mul_sel = MUL_PROBE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DEC;
        end
      end
      S_DEC: begin
        state_d = S_IDLE;
        case (sts_i.req)
          REQ_RELEASE: begin
            cmd_o.clear = 1'b1;
            mode_d      = MODE_COAST;
          end
          REQ_MOVE: begin
            if (enable_i) begin
              mode_d = MODE_DRAG;
              if (!sts_i.elapsed_zero) begin
                cmd_o.div_sample = 1'b1;
                state_d          = S_DIVS;
              end
            end
          end
          REQ_TICK: begin
            if (enable_i && mode_q == MODE_DRAG) begin
              cmd_o.tick_add = 1'b1;
            end else if (enable_i && mode_q == MODE_COAST) begin
              cmd_o.mul_en  = 1'b1;
              cmd_o.mul_sel = MUL_PROBE;
              state_d       = S_PROBE;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_DIVS: begin
        if (sts_i.div_done) begin
          cmd_o.ring_write = 1'b1;
          cmd_o.sum_start  = 1'b1;
          state_d          = S_SUM;
        end
      end
      S_SUM: begin
        cmd_o.acc_sum = 1'b1;
        if (sts_i.scan_done) begin
          cmd_o.sel_init  = 1'b1;
          cmd_o.sel_start = 1'b1;
          state_d         = S_SEL;
        end
      end
      S_SEL: begin
        cmd_o.acc_sel = 1'b1;
        if (sts_i.scan_done) state_d = S_TAKE;
      end
      S_TAKE: begin
        cmd_o.take = 1'b1;
        if (sts_i.last_pick) begin
          state_d = S_KST;
        end else begin
          cmd_o.sel_start = 1'b1;
          state_d         = S_SEL;
        end
      end
      S_KST: begin
        cmd_o.div_keep = 1'b1;
        state_d        = S_DIVK;
      end
      S_DIVK: begin
        if (sts_i.div_done) begin
          cmd_o.speed_from_div = 1'b1;
          state_d              = S_MULD;
        end
      end
      S_MULD: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_ELAPSED;
        state_d       = S_STEPD;
      end
      S_STEPD: begin
        cmd_o.step_drag = 1'b1;
        state_d         = S_EMIT;
      end
      S_PROBE: begin
        if (sts_i.probe_over) begin
          cmd_o.mul_en  = 1'b1;
          cmd_o.mul_sel = MUL_DECAY;
          state_d       = S_DECAY;
        end else begin
          cmd_o.set_stop = 1'b1;
          mode_d         = MODE_IDLE;
          state_d        = S_EMIT;
        end
      end
      S_DECAY: begin
        cmd_o.speed_from_mul = 1'b1;
        state_d              = S_SPD;
      end
      S_SPD: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_STEP_DT;
        state_d       = S_STEPC;
      end
      S_STEPC: begin
        cmd_o.step_coast = 1'b1;
        state_d          = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mode_q  <= MODE_IDLE;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
    end
  end

endmodule

// ===== rtl/trimmed_velocity_inertia.sv =====
// ----------------------------------------------------------------------------
// trimmed_velocity_inertia: drag velocity estimator with coasting
// Trimmed-mean speed over a ring of samples, exponential decay on release.
// ----------------------------------------------------------------------------
// One item at a time. A tick adds dt to the elapsed time while dragging and,
// while coasting, probes the speed against the stop threshold, then decays
// it and computes a step, or stops. A move with nonzero elapsed time runs the
// bit-serial divider for the sample, scans the one read port of the sample
// ring once for the sum and once per kept sample, and divides again for the
// average. A finished result sits in an output register, so the next item is
// taken while it waits. Register writes are always ready.
module trimmed_velocity_inertia
  import tvi_pkg::*;
#(
  parameter int unsigned RING_DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tvi_in_if.sink     in_i,
  tvi_out_if.source  out_o,
  tvi_cfg_if.sink    cfg_i
);

  cfg_t cfg_q;
  cmd_t cmd;
  sts_t sts;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable         <= RST_ENABLE;
      cfg_q.decay_factor   <= RST_DECAY;
      cfg_q.stop_threshold <= RST_THRESHOLD;
      cfg_q.keep_count     <= RST_KEEP;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_ENABLE:    cfg_q.enable         <= cfg_i.data[0];
        CFG_DECAY:     cfg_q.decay_factor   <= cfg_i.data;
        CFG_THRESHOLD: cfg_q.stop_threshold <= cfg_i.data;
        CFG_KEEP:      cfg_q.keep_count     <= cfg_i.data[4:0];
        default:       cfg_q.enable         <= cfg_q.enable;
      endcase
    end
  end

  tvi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .enable_i   (cfg_q.enable),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tvi_dp #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_i         (cfg_q),
    .req_type_i    (in_i.req_type),
    .dt_i          (in_i.dt),
    .delta_i       (in_i.delta),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .event_kind_o  (out_o.event_kind),
    .step_amount_o (out_o.step_amount),
    .speed_o       (out_o.speed)
  );

endmodule
